>>> rtl/core/snd_pkg.sv
// ----------------------------------------------------------------------------
// snd_pkg
// Shared types and constants for the single-level name directory.
// ----------------------------------------------------------------------------
package snd_pkg;

  localparam int unsigned HeadW     = 64;
  localparam int unsigned TailW     = 8;
  localparam int unsigned NameW     = HeadW + TailW;
  localparam int unsigned NameBytes = HeadW / 8;
  localparam int unsigned TotalW    = 5;

  typedef enum logic [1:0] {
    REQ_CREATE = 2'd0,
    REQ_DELETE = 2'd1,
    REQ_SEARCH = 2'd2,
    REQ_LIST   = 2'd3
  } req_e;

  typedef enum logic [3:0] {
    ST_CREATED     = 4'd0,
    ST_DUPLICATE   = 4'd1,
    ST_FULL        = 4'd2,
    ST_DELETED     = 4'd3,
    ST_DEL_MISSING = 4'd4,
    ST_FOUND       = 4'd5,
    ST_NOT_FOUND   = 4'd6,
    ST_LIST_ENTRY  = 4'd7,
    ST_LIST_EMPTY  = 4'd8
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE      = 3'd0,
    S_SCAN      = 3'd1,
    S_RESULT    = 3'd2,
    S_DEL_RD    = 3'd3,
    S_DEL_WR    = 3'd4,
    S_LIST_RD   = 3'd5,
    S_LIST_EMIT = 3'd6
  } state_e;

  // controller -> datapath
  typedef struct packed {
    logic    load;        // capture request and restart the table walk
    logic    scan_step;   // read next entry, compare the previous one
    logic    latch_slot;  // remember index of the matching entry
    logic    rd_last;     // read the last stored entry
    logic    wr_new;      // append the request name
    logic    wr_move;     // move last entry into the matched slot
    logic    list_rd;     // read entry at the walk index
    logic    list_next;   // advance the walk index
    logic    emit;        // load the output register
    logic    emit_entry;  // output word carries a stored entry
    status_e status;
  } snd_cmd_t;

  // datapath -> controller
  typedef struct packed {
    req_e req;
    req_e req_in;     // request type offered at the input port
    logic match;
    logic exhausted;
    logic full;
    logic empty;
    logic list_last;
    logic out_free;
  } snd_sts_t;

endpackage

>>> rtl/core/single_level_name_directory.sv
// ----------------------------------------------------------------------------
// single_level_name_directory
// Table of up to MAX_NAMES unique 9-byte names with create, delete, search
// and list requests.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel (in_valid_i / in_ready_o) carries req_type_i plus the name
//   as name_head_i (bytes 0..7) and name_tail_i (byte 8). One request is in
//   work at a time; in_ready_o is high only while the sequencer is idle.
//   Result channel (out_valid_o / out_ready_i) returns one word per create,
//   delete or search, and one word per stored entry for a list (last_o marks
//   the final word), or a single list-empty word.
//   Table walk: a create, search or delete reads one entry per cycle from the
//   name RAM until a match or the end of the table; a delete hit then reads
//   the last entry and moves it into the freed slot. A list reads an entry,
//   emits its word, and only then reads the next entry.
//   Reset empties the table at once; no clearing pass is needed.
//   When the receiver stalls, the result word is held in the output register
//   and the sequencer waits before issuing the next word.
// ----------------------------------------------------------------------------
module single_level_name_directory import snd_pkg::*; #(
  parameter int unsigned MAX_NAMES = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [1:0]        req_type_i,
  input  logic [HeadW-1:0]  name_head_i,
  input  logic [TailW-1:0]  name_tail_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [3:0]        status_o,
  output logic [HeadW-1:0]  entry_head_o,
  output logic [TailW-1:0]  entry_tail_o,
  output logic [TotalW-1:0] entry_total_o,
  output logic              last_o
);

  snd_cmd_t cmd;
  snd_sts_t sts;

  snd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  snd_dp #(
    .MaxNames (MAX_NAMES)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .req_type_i    (req_type_i),
    .name_head_i   (name_head_i),
    .name_tail_i   (name_tail_i),
    .out_ready_i   (out_ready_i),
    .out_valid_o   (out_valid_o),
    .status_o      (status_o),
    .entry_head_o  (entry_head_o),
    .entry_tail_o  (entry_tail_o),
    .entry_total_o (entry_total_o),
    .last_o        (last_o)
  );

`ifndef NO_ASSERTIONS
  // only list words may leave a request open
  a_last_on_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != ST_LIST_ENTRY) |-> last_o)
    else $error("non-list word without last");

  a_entry_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != ST_LIST_ENTRY) |->
      (entry_head_o == '0) && (entry_tail_o == '0))
    else $error("non-list word carries entry bytes");

  // sequencer leaves idle once a request is taken
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("request accepted while busy");

  a_created_total: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == ST_CREATED) |-> (entry_total_o != '0))
    else $error("create reported with empty table");
`endif

endmodule

>>> rtl/core/snd_ram.sv
// ----------------------------------------------------------------------------
// snd_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module snd_ram #(
  parameter int unsigned Width = 72,
  parameter int unsigned Depth = 16,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/core/snd_dp.sv
// ----------------------------------------------------------------------------
// snd_dp
// Datapath: name canonicalization, name table RAM, walk index, occupancy
// and the output word register.
// ----------------------------------------------------------------------------
module snd_dp import snd_pkg::*; #(
  parameter int unsigned MaxNames = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  snd_cmd_t          cmd_i,
  output snd_sts_t          sts_o,
  input  logic [1:0]        req_type_i,
  input  logic [HeadW-1:0]  name_head_i,
  input  logic [TailW-1:0]  name_tail_i,
  input  logic              out_ready_i,
  output logic              out_valid_o,
  output logic [3:0]        status_o,
  output logic [HeadW-1:0]  entry_head_o,
  output logic [TailW-1:0]  entry_tail_o,
  output logic [TotalW-1:0] entry_total_o,
  output logic              last_o
);

  localparam int unsigned IdxW = (MaxNames > 1) ? $clog2(MaxNames) : 1;
  localparam int unsigned CntW = $clog2(MaxNames + 1);

  // canonical name: bytes after the first zero byte read as zero
  logic [NameBytes-1:0] keep;
  logic [HeadW-1:0]     head_c;
  logic [TailW-1:0]     tail_c;

  always_comb begin
    keep[0] = (name_head_i[7:0] != 8'h00);
    for (int b = 1; b < NameBytes; b++) begin
      keep[b] = keep[b-1] && (name_head_i[8*b +: 8] != 8'h00);
    end
    for (int b = 0; b < NameBytes; b++) begin
      head_c[8*b +: 8] = keep[b] ? name_head_i[8*b +: 8] : 8'h00;
    end
    tail_c = keep[NameBytes-1] ? name_tail_i : '0;
  end

  req_e             req_q;
  logic [NameW-1:0] key_q;
  logic [CntW-1:0]  idx_q,  idx_d;
  logic             pend_q, pend_d;
  logic [IdxW-1:0]  slot_q;
  logic [CntW-1:0]  occ_q,  occ_d;

  logic              out_valid_q;
  status_e           status_q;
  logic [HeadW-1:0]  head_q;
  logic [TailW-1:0]  tail_q;
  logic [TotalW-1:0] total_q;
  logic              last_q;

  logic             ram_we, ram_re;
  logic [IdxW-1:0]  ram_waddr, ram_raddr;
  logic [NameW-1:0] ram_wdata, ram_rdata;

  logic            in_range;
  logic [CntW-1:0] occ_m1, idx_m1;
  logic [CntW:0]   idx_inc;
  logic            list_last;

  always_comb begin
    in_range  = (idx_q < occ_q);
    occ_m1    = occ_q - {{(CntW-1){1'b0}}, 1'b1};
    idx_m1    = idx_q - {{(CntW-1){1'b0}}, 1'b1};
    idx_inc   = {1'b0, idx_q} + {{CntW{1'b0}}, 1'b1};
    list_last = (idx_inc == {1'b0, occ_q});

    ram_re    = (cmd_i.scan_step && in_range) || cmd_i.list_rd || cmd_i.rd_last;
    ram_raddr = cmd_i.rd_last ? occ_m1[IdxW-1:0] : idx_q[IdxW-1:0];
    ram_we    = cmd_i.wr_new || cmd_i.wr_move;
    ram_waddr = cmd_i.wr_move ? slot_q : occ_q[IdxW-1:0];
    ram_wdata = cmd_i.wr_move ? ram_rdata : key_q;

    occ_d = occ_q;
    if (cmd_i.wr_new) begin
      occ_d = occ_q + {{(CntW-1){1'b0}}, 1'b1};
    end else if (cmd_i.wr_move) begin
      occ_d = occ_m1;
    end

    idx_d  = idx_q;
    pend_d = pend_q;
    if (cmd_i.load) begin
      idx_d  = '0;
      pend_d = 1'b0;
    end else begin
      if (cmd_i.scan_step) begin
        pend_d = in_range;
        if (in_range) begin
          idx_d = idx_inc[CntW-1:0];
        end
      end
      if (cmd_i.list_next) begin
        idx_d = idx_inc[CntW-1:0];
      end
    end
  end

  snd_ram #(
    .Width (NameW),
    .Depth (MaxNames)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      pend_q      <= 1'b0;
      occ_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      idx_q  <= idx_d;
      pend_q <= pend_d;
      occ_q  <= occ_d;
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      req_q <= req_e'(req_type_i);
      key_q <= {tail_c, head_c};
    end
    // a pending compare belongs to the entry just before the walk index
    if (cmd_i.latch_slot) begin
      slot_q <= idx_m1[IdxW-1:0];
    end
    if (cmd_i.emit) begin
      status_q <= cmd_i.status;
      head_q   <= cmd_i.emit_entry ? ram_rdata[HeadW-1:0] : '0;
      tail_q   <= cmd_i.emit_entry ? ram_rdata[NameW-1:HeadW] : '0;
      total_q  <= TotalW'(occ_d);
      last_q   <= cmd_i.emit_entry ? list_last : 1'b1;
    end
  end

  always_comb begin
    sts_o.req       = req_q;
    sts_o.req_in    = req_e'(req_type_i);
    sts_o.match     = pend_q && (ram_rdata == key_q);
    sts_o.exhausted = !pend_q && !in_range;
    sts_o.full      = (occ_q == CntW'(MaxNames));
    sts_o.empty     = (occ_q == '0);
    sts_o.list_last = list_last;
    sts_o.out_free  = !out_valid_q || out_ready_i;
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = status_q;
  assign entry_head_o  = head_q;
  assign entry_tail_o  = tail_q;
  assign entry_total_o = total_q;
  assign last_o        = last_q;

endmodule

>>> rtl/core/snd_ctrl.sv
// ----------------------------------------------------------------------------
// snd_ctrl
// Request sequencer: table walk, create / delete / search decisions and the
// list stream.
// ----------------------------------------------------------------------------
module snd_ctrl import snd_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  snd_sts_t sts_i,
  output snd_cmd_t cmd_o
);

  state_e state_q, state_d;
  logic   found_q, found_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      found_q <= 1'b0;
    end else begin
      state_q <= state_d;
      found_q <= found_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    found_d    = found_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          found_d    = 1'b0;
          state_d    = (sts_i.req_in == REQ_LIST) ? S_LIST_RD : S_SCAN;
        end
      end
      S_SCAN: begin
        if (sts_i.match) begin
          cmd_o.latch_slot = 1'b1;
          found_d          = 1'b1;
          state_d          = (sts_i.req == REQ_DELETE) ? S_DEL_RD : S_RESULT;
        end else if (sts_i.exhausted) begin
          state_d = S_RESULT;
        end else begin
          cmd_o.scan_step = 1'b1;
        end
      end
      S_RESULT: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = S_IDLE;
          unique case (sts_i.req)
            REQ_CREATE: begin
              if (found_q) begin
                cmd_o.status = ST_DUPLICATE;
              end else if (sts_i.full) begin
                cmd_o.status = ST_FULL;
              end else begin
                cmd_o.status = ST_CREATED;
                cmd_o.wr_new = 1'b1;
              end
            end
            REQ_DELETE: cmd_o.status = ST_DEL_MISSING;
            REQ_SEARCH: cmd_o.status = found_q ? ST_FOUND : ST_NOT_FOUND;
            REQ_LIST:   cmd_o.status = ST_LIST_EMPTY;
            default:    cmd_o.status = ST_NOT_FOUND;
          endcase
        end
      end
      S_DEL_RD: begin
        cmd_o.rd_last = 1'b1;
        state_d       = S_DEL_WR;
      end
      S_DEL_WR: begin
        if (sts_i.out_free) begin
          cmd_o.wr_move = 1'b1;
          cmd_o.emit    = 1'b1;
          cmd_o.status  = ST_DELETED;
          state_d       = S_IDLE;
        end
      end
      S_LIST_RD: begin
        if (sts_i.empty) begin
          state_d = S_RESULT;
        end else begin
          cmd_o.list_rd = 1'b1;
          state_d       = S_LIST_EMIT;
        end
      end
      S_LIST_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.emit       = 1'b1;
          cmd_o.emit_entry = 1'b1;
          cmd_o.status     = ST_LIST_ENTRY;
          cmd_o.list_next  = 1'b1;
          state_d          = sts_i.list_last ? S_IDLE : S_LIST_RD;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule

>>> tb/tb_single_level_name_directory.sv
// ----------------------------------------------------------------------------
// tb_single_level_name_directory
// Self-checking bench for the name directory. A scoreboard class tracks its
// own copy of the name table, predicts every result word from each accepted
// request and checks the words that come back in order. The stimulus starts
// with a directed pass over the empty and full table and the terminator
// rules. A random pass then swings the table between empty and full, with
// random gaps and stalls on both channels.
// ----------------------------------------------------------------------------
module tb_single_level_name_directory;
  import snd_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MaxNames    = 16;
  localparam int unsigned ClkPeriod   = 12;
  localparam int unsigned RandomReqs  = 403;
  localparam int unsigned PoolSize    = 24;
  localparam int unsigned HoldCycles  = 400;
  localparam int unsigned DrainCycles = 60;
  localparam int unsigned MaxPrinted  = 30;

  typedef struct {
    status_e            status;
    logic [HeadW-1:0]   head;
    logic [TailW-1:0]   tail;
    logic [TotalW-1:0]  total;
    logic               last;
  } dir_word_t;

  class dir_scoreboard;
    logic [HeadW-1:0] heads [MaxNames];
    logic [TailW-1:0] tails [MaxNames];
    int unsigned      occupancy;
    dir_word_t        pending_words [$];
    int unsigned      n_mismatch;
    int unsigned      n_checked;
    int unsigned      n_req [4];
    int unsigned      n_status [9];

    function new();
      occupancy  = 0;
      n_mismatch = 0;
      n_checked  = 0;
      foreach (n_req[i]) n_req[i] = 0;
      foreach (n_status[i]) n_status[i] = 0;
    endfunction

    // a name ends at its first zero byte; everything above it reads as zero
    function void canon_name(inout logic [HeadW-1:0] h, inout logic [TailW-1:0] t);
      for (int b = 0; b < NameBytes; b++) begin
        if (h[8*b +: 8] == 8'h00) begin
          h = h & ((64'd1 << (8 * b)) - 64'd1);
          t = '0;
          return;
        end
      end
    endfunction

    function int find_name(logic [HeadW-1:0] h, logic [TailW-1:0] t);
      for (int i = 0; i < occupancy; i++) begin
        if (heads[i] == h && tails[i] == t) return i;
      end
      return -1;
    endfunction

    function void push_word(status_e st, logic [HeadW-1:0] h, logic [TailW-1:0] t,
                            logic lst);
      dir_word_t w;
      w.status = st;
      w.head   = h;
      w.tail   = t;
      w.total  = TotalW'(occupancy);
      w.last   = lst;
      pending_words.push_back(w);
      n_status[int'(st)]++;
    endfunction

    function void note_request(req_e req, logic [HeadW-1:0] h, logic [TailW-1:0] t);
      int slot;
      canon_name(h, t);
      n_req[int'(req)]++;
      case (req)
        REQ_CREATE: begin
          if (find_name(h, t) >= 0) begin
            push_word(ST_DUPLICATE, '0, '0, 1'b1);
          end else if (occupancy >= MaxNames) begin
            push_word(ST_FULL, '0, '0, 1'b1);
          end else begin
            heads[occupancy] = h;
            tails[occupancy] = t;
            occupancy++;
            push_word(ST_CREATED, '0, '0, 1'b1);
          end
        end
        REQ_DELETE: begin
          slot = find_name(h, t);
          if (slot < 0) begin
            push_word(ST_DEL_MISSING, '0, '0, 1'b1);
          end else begin
            // last entry fills the hole
            heads[slot] = heads[occupancy-1];
            tails[slot] = tails[occupancy-1];
            occupancy--;
            push_word(ST_DELETED, '0, '0, 1'b1);
          end
        end
        REQ_SEARCH: begin
          push_word((find_name(h, t) >= 0) ? ST_FOUND : ST_NOT_FOUND, '0, '0, 1'b1);
        end
        default: begin
          if (occupancy == 0) begin
            push_word(ST_LIST_EMPTY, '0, '0, 1'b1);
          end else begin
            for (int i = 0; i < occupancy; i++) begin
              push_word(ST_LIST_ENTRY, heads[i], tails[i], (i + 1 == occupancy));
            end
          end
        end
      endcase
    endfunction

    task report(string msg);
      n_mismatch++;
      if (n_mismatch <= MaxPrinted) $display("MISMATCH at %0t ns: %s", $realtime, msg);
    endtask

    task check_word(logic [3:0] st, logic [HeadW-1:0] h, logic [TailW-1:0] t,
                    logic [TotalW-1:0] total, logic lst);
      dir_word_t w;
      n_checked++;
      if (pending_words.size() == 0) begin
        report($sformatf("result word with nothing expected, status %0d", st));
        return;
      end
      w = pending_words.pop_front();
      if (st !== w.status)
        report($sformatf("status %0d, expected %s", st, w.status.name()));
      if (h !== w.head)
        report($sformatf("entry_head %h, expected %h", h, w.head));
      if (t !== w.tail)
        report($sformatf("entry_tail %h, expected %h", t, w.tail));
      if (total !== w.total)
        report($sformatf("entry_total %0d, expected %0d", total, w.total));
      if (lst !== w.last)
        report($sformatf("last %b, expected %b", lst, w.last));
    endtask
  endclass

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              in_valid_i;
  logic              in_ready_o;
  logic [1:0]        req_type_i;
  logic [HeadW-1:0]  name_head_i;
  logic [TailW-1:0]  name_tail_i;
  logic              out_valid_o;
  logic              out_ready_i;
  logic [3:0]        status_o;
  logic [HeadW-1:0]  entry_head_o;
  logic [TailW-1:0]  entry_tail_o;
  logic [TotalW-1:0] entry_total_o;
  logic              last_o;

  dir_scoreboard sb = new();

  bit quiet    = 1'b0;  // no gaps on either side
  bit hold_req = 1'b0;  // ask the receiver for one long stall

  logic [HeadW-1:0] pool_head [PoolSize];
  logic [TailW-1:0] pool_tail [PoolSize];
  int unsigned      pool_len  [PoolSize];

  single_level_name_directory #(
    .MAX_NAMES(MaxNames)
  ) i_dut (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .req_type_i,
    .name_head_i,
    .name_tail_i,
    .out_valid_o,
    .out_ready_i,
    .status_o,
    .entry_head_o,
    .entry_tail_o,
    .entry_total_o,
    .last_o
  );

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  initial begin
    #20_000_000;
    $display("Verification failed");
    $finish;
  end

  // mostly short gaps, a few long ones
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (quiet || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // enter and leave at a falling edge
  task automatic send_request(req_e req, logic [HeadW-1:0] h, logic [TailW-1:0] t);
    in_valid_i  = 1'b1;
    req_type_i  = req;
    name_head_i = h;
    name_tail_i = t;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
  endtask

  task automatic idle_gap(int unsigned n);
    if (n > 0) begin
      in_valid_i = 1'b0;
      repeat (n) @(negedge clk_i);
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o)
        sb.note_request(req_e'(req_type_i), name_head_i, name_tail_i);
      if (out_valid_o && out_ready_i)
        sb.check_word(status_o, entry_head_o, entry_tail_o, entry_total_o, last_o);
    end
  end

  // result side back-pressure
  initial begin
    int unsigned stall_left;
    stall_left  = 0;
    out_ready_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        out_ready_i = 1'b0;
        repeat (HoldCycles) @(negedge clk_i);
        hold_req = 1'b0;
      end else if (quiet) begin
        out_ready_i = 1'b1;
        stall_left  = 0;
      end else if (stall_left > 0) begin
        out_ready_i = 1'b0;
        stall_left--;
      end else begin
        out_ready_i = 1'b1;
        if ($urandom_range(0, 99) < 15) stall_left = pick_gap();
      end
    end
  end

  initial begin
    logic [HeadW-1:0] h;
    logic [TailW-1:0] t;
    logic [HeadW-1:0] ones_head;
    req_e             req;
    int unsigned      r;
    int unsigned      k;
    bit               filling;

    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    req_type_i  = REQ_CREATE;
    name_head_i = '0;
    name_tail_i = '0;
    filling     = 1'b1;
    ones_head   = '1;

    // pool of terminated names, some using all nine bytes
    for (int i = 0; i < PoolSize; i++) begin
      pool_len[i]  = (i % 4 == 0) ? 9 : $urandom_range(1, 9);
      pool_head[i] = '0;
      pool_tail[i] = '0;
      for (int b = 0; b < pool_len[i]; b++) begin
        if (b < NameBytes) pool_head[i][8*b +: 8] = 8'($urandom_range(1, 255));
        else pool_tail[i] = 8'($urandom_range(1, 255));
      end
    end

    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed: empty table, terminator rules, swap on delete, full table
    send_request(REQ_LIST, '0, '0);                              idle_gap(pick_gap());
    send_request(REQ_SEARCH, 64'h41, '0);                        idle_gap(pick_gap());
    send_request(REQ_DELETE, ones_head, 8'hFF);                  idle_gap(pick_gap());
    send_request(REQ_CREATE, '0, '0);                            idle_gap(pick_gap());
    send_request(REQ_CREATE, ones_head, 8'hFF);                  idle_gap(pick_gap());
    send_request(REQ_CREATE, 64'h41, '0);                        idle_gap(pick_gap());
    send_request(REQ_CREATE, 64'hDEAD_BEEF_CAFE_0041, 8'h5A);    idle_gap(pick_gap());
    send_request(REQ_SEARCH, 64'h7700_0000_0000_0041, 8'hA5);    idle_gap(pick_gap());
    send_request(REQ_CREATE, 64'h1234_5678_9ABC_DE00, 8'hC3);    idle_gap(pick_gap());
    send_request(REQ_DELETE, 64'hFFFF_FFFF_FFFF_FF00, 8'hFF);    idle_gap(pick_gap());
    send_request(REQ_LIST, '0, '0);                              idle_gap(pick_gap());
    for (int i = 0; i < MaxNames - 2; i++) begin
      send_request(REQ_CREATE, pool_head[i], pool_tail[i]);
      idle_gap(pick_gap());
    end
    send_request(REQ_CREATE, pool_head[MaxNames-2], pool_tail[MaxNames-2]);
    idle_gap(pick_gap());
    send_request(REQ_CREATE, ones_head, 8'hFF);                  idle_gap(pick_gap());
    send_request(REQ_LIST, '0, '0);                              idle_gap(pick_gap());

    // random: drift toward full, then toward empty, and back
    for (int n = 0; n < RandomReqs; n++) begin
      if (n == 140) hold_req = 1'b1;
      if (n == 260) begin
        idle_gap(1);
        while (sb.pending_words.size() != 0) @(negedge clk_i);
      end
      quiet = (n >= 300 && n < 360);

      if (sb.occupancy >= MaxNames) filling = 1'b0;
      else if (sb.occupancy == 0) filling = 1'b1;

      r = $urandom_range(0, 99);
      if (filling)
        req = (r < 55) ? REQ_CREATE : (r < 70) ? REQ_DELETE : (r < 92) ? REQ_SEARCH : REQ_LIST;
      else
        req = (r < 15) ? REQ_CREATE : (r < 60) ? REQ_DELETE : (r < 90) ? REQ_SEARCH : REQ_LIST;

      r = $urandom_range(0, 99);
      if (r < 8) begin
        h = {$urandom, $urandom};
        t = 8'($urandom);
      end else if (r < 12) begin
        // empty name with junk behind the terminator
        h = {$urandom, $urandom} & ~64'hFF;
        t = 8'($urandom);
      end else begin
        k = $urandom_range(0, PoolSize - 1);
        h = pool_head[k];
        t = pool_tail[k];
        if (pool_len[k] < NameBytes && $urandom_range(0, 2) == 0) begin
          for (int b = pool_len[k] + 1; b < NameBytes; b++) h[8*b +: 8] = 8'($urandom);
          t = 8'($urandom);
        end
      end
      send_request(req, h, t);
      idle_gap(pick_gap());
    end
    in_valid_i = 1'b0;

    while (sb.pending_words.size() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);

    $display("Requests: %0d create, %0d delete, %0d search, %0d list; %0d words checked",
             sb.n_req[REQ_CREATE], sb.n_req[REQ_DELETE], sb.n_req[REQ_SEARCH],
             sb.n_req[REQ_LIST], sb.n_checked);
    $display("Outcomes: %0d created, %0d dup, %0d full, %0d deleted, %0d missing, %0d found,"
             , sb.n_status[ST_CREATED], sb.n_status[ST_DUPLICATE], sb.n_status[ST_FULL],
             sb.n_status[ST_DELETED], sb.n_status[ST_DEL_MISSING], sb.n_status[ST_FOUND],
             " %0d not found, %0d listed, %0d empty lists; %0d mismatches",
             sb.n_status[ST_NOT_FOUND], sb.n_status[ST_LIST_ENTRY],
             sb.n_status[ST_LIST_EMPTY], sb.n_mismatch);
    if (sb.n_mismatch == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
